// ===== sv/bsah_pkg.sv =====
// Shared types, constants and helper functions of the binned SAH split selector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bsah_pkg;

	localparam int COORD_BITS = 16;
	localparam int NUM_BINS   = 16;
	localparam int BIN_W      = $clog2(NUM_BINS);
	localparam int CNT_W      = 11;
	localparam int COST_W     = 44;
	localparam int EXT_W      = COORD_BITS + 1;       // centroid extent, doubled coordinates
	localparam int TW         = EXT_W + BIN_W;        // bin thresholds and scaled offsets
	localparam int HA_W       = 2 * COORD_BITS + 2;   // half area of one box
	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [1:0] {
		MODE_SAH        = 2'd0,
		MODE_MEDIAN     = 2'd1,
		MODE_COINCIDENT = 2'd2,
		MODE_LEAF       = 2'd3
	} mode_t;

	typedef logic signed [COORD_BITS:0] cent_t;
	typedef logic signed [EXT_W:0]      sext_t;

	typedef struct packed {
		logic [2:0][COORD_BITS-1:0] lo;
		logic [2:0][COORD_BITS-1:0] hi;
	} box_t;

	typedef struct packed {
		box_t              node;
		mode_t             mode;
		logic [1:0]        axis;
		logic [BIN_W-1:0]  bin;
		logic [CNT_W-1:0]  left;
		logic [COST_W-1:0] cost;
	} res_t;

	typedef struct packed {
		logic             ld;
		logic             best_clr;
		logic             thr_wr;
		logic             idx_clr;
		logic             mem_rd;
		logic             bin_calc;
		logic             bin_acc;
		logic             suf_step;
		logic             pre_step;
		logic             first;
		logic             fin;
		logic [BIN_W-1:0] k;
		logic [1:0]       axis;
	} cmd_t;

	typedef struct packed {
		logic       n_lt2;
		logic       all_zero;
		logic [2:0] ext_pos;
		logic       idx_last;
		logic       pipe_busy;
		logic       res_slot_free;
	} sts_t;

	function automatic box_t box_union(input box_t a, input box_t b);
		box_t r;
		r = a;
		for (int i = 0; i < 3; i++) begin
			if ($signed(b.lo[i]) < $signed(a.lo[i])) r.lo[i] = b.lo[i];
			if ($signed(b.hi[i]) > $signed(a.hi[i])) r.hi[i] = b.hi[i];
		end
		return r;
	endfunction

	// Widest axis; y and then z win only when strictly wider than x.
	function automatic logic [1:0] widest(input sext_t e0, input sext_t e1, input sext_t e2);
		if (e1 > e0 && e1 >= e2) return AXIS_Y;
		if (e2 > e0 && e2 >= e1) return AXIS_Z;
		return AXIS_X;
	endfunction

	// Box side length, zero for an inverted side.
	function automatic logic [COORD_BITS-1:0] side(input logic [COORD_BITS-1:0] lo,
			input logic [COORD_BITS-1:0] hi);
		logic signed [COORD_BITS:0] d;
		d = $signed({hi[COORD_BITS-1], hi}) - $signed({lo[COORD_BITS-1], lo});
		return (d > 0) ? d[COORD_BITS-1:0] : '0;
	endfunction

endpackage

// ===== sv/bsah_if.sv =====
// Valid/ready channel interfaces for primitive boxes and split results.
// Depends on bsah_pkg for field widths.
`timescale 1ns / 1ps

interface bsah_box_if import bsah_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] box_min_x;
	logic signed [COORD_BITS-1:0] box_min_y;
	logic signed [COORD_BITS-1:0] box_min_z;
	logic signed [COORD_BITS-1:0] box_max_x;
	logic signed [COORD_BITS-1:0] box_max_y;
	logic signed [COORD_BITS-1:0] box_max_z;
	logic                         is_last;

	modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, is_last, input ready);
	modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, is_last, output ready);
endinterface

interface bsah_res_if import bsah_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] node_min_x;
	logic signed [COORD_BITS-1:0] node_min_y;
	logic signed [COORD_BITS-1:0] node_min_z;
	logic signed [COORD_BITS-1:0] node_max_x;
	logic signed [COORD_BITS-1:0] node_max_y;
	logic signed [COORD_BITS-1:0] node_max_z;
	logic [1:0]                   split_mode;
	logic [1:0]                   split_axis;
	logic [BIN_W-1:0]             split_bin;
	logic [CNT_W-1:0]             left_count;
	logic [COST_W-1:0]            best_cost;

	modport source (output valid, node_min_x, node_min_y, node_min_z, node_max_x, node_max_y,
		node_max_z, split_mode, split_axis, split_bin, left_count, best_cost, input ready);
	modport sink (input valid, node_min_x, node_min_y, node_min_z, node_max_x, node_max_y,
		node_max_z, split_mode, split_axis, split_bin, left_count, best_cost, output ready);
endinterface

// ===== sv/binned_sah_split_selection.sv =====
// Top level of the binned SAH split selector: channel adaptation, controller, datapath.
// Depends on bsah_pkg, bsah_if, bsah_ctrl and bsah_datapath.
`timescale 1ns / 1ps

// Boxes of one node stream in on "box", one per cycle, and are stored (up to
// MAX_PRIMS; later boxes are dropped, their is_last still counts). The box
// marked is_last starts the evaluation: each axis is checked in turn, and for
// one with a nonzero centroid extent the 15 bin thresholds are built, every
// stored primitive then passes store read, bin index and bin update, a suffix
// sweep over the 16 bins and a prefix sweep over 15 bins follow, the 5-stage
// cost pipeline drains and the axis advances. For a large node the
// per-primitive pass over the single store read port dominates the
// evaluation. Input is not taken during evaluation.
// The result sits in an output register, so loading of the next node begins
// while the result waits on "res"; a further evaluation runs up to S_FIN and
// waits there until that result is taken.
module binned_sah_split_selection import bsah_pkg::*; #(
	parameter int MAX_PRIMS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	bsah_box_if.sink   box,
	bsah_res_if.source res
);

	box_t in_box;
	cmd_t cmd;
	sts_t sts;
	res_t res_d;

	// pack the input transaction, axis 0 is x
	always_comb begin
		in_box.lo[0] = box.box_min_x;
		in_box.lo[1] = box.box_min_y;
		in_box.lo[2] = box.box_min_z;
		in_box.hi[0] = box.box_max_x;
		in_box.hi[1] = box.box_max_y;
		in_box.hi[2] = box.box_max_z;
	end

	bsah_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (box.valid),
		.in_last  (box.is_last),
		.in_ready (box.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsah_datapath #(
		.MAX_PRIMS (MAX_PRIMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_box    (in_box),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res_d),
		.res_valid (res.valid),
		.res_ready (res.ready)
	);

	// unpack the result transaction
	assign res.node_min_x = res_d.node.lo[0];
	assign res.node_min_y = res_d.node.lo[1];
	assign res.node_min_z = res_d.node.lo[2];
	assign res.node_max_x = res_d.node.hi[0];
	assign res.node_max_y = res_d.node.hi[1];
	assign res.node_max_z = res_d.node.hi[2];
	assign res.split_mode = res_d.mode;
	assign res.split_axis = res_d.axis;
	assign res.split_bin  = res_d.bin;
	assign res.left_count = res_d.left;
	assign res.best_cost  = res_d.cost;

endmodule

// ===== sv/bsah_datapath.sv =====
// Datapath: primitive store, node and centroid bounds, binning, sweeps, cost pipeline.
// Depends on bsah_pkg; driven by bsah_ctrl through cmd_t, reports through sts_t.
`timescale 1ns / 1ps

module bsah_datapath import bsah_pkg::*; #(
	parameter int MAX_PRIMS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  box_t in_box,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t res,
	output logic res_valid,
	input  logic res_ready
);

	localparam int PW = $clog2(MAX_PRIMS);
	localparam int CW = $clog2(MAX_PRIMS + 1);
	localparam int PROD_W = HA_W + CW;

	box_t                mem [MAX_PRIMS];
	box_t                mem_q;
	logic [CW-1:0]       cnt_q;
	logic [PW-1:0]       idx_q;
	box_t                node_q;
	cent_t [2:0]         cmin_q, cmax_q;

	logic [TW-1:0]       thr_q [NUM_BINS-1];
	logic [TW-1:0]       thr_acc_q;
	logic [BIN_W-1:0]    bin_s1;
	box_t                box_s1;
	logic [CW-1:0]       bcnt_q [NUM_BINS];
	box_t                bbox_q [NUM_BINS];
	box_t                suf_box_q [NUM_BINS];
	logic [CW-1:0]       sc_q [NUM_BINS];
	box_t                suf_acc_q, pre_acc_q;
	logic [CW-1:0]       suf_cnt_q, pre_cnt_q;

	logic [BIN_W-1:0]    lk_s1;
	logic                lv_s1;
	logic [2:0][COORD_BITS-1:0] dl_s2, dr_s2;
	logic [CW-1:0]       cl_s2, cr_s2, cl_s3, cr_s3, cl_s4, cr_s4, cl_s5;
	logic [BIN_W-1:0]    bk_s2, bk_s3, bk_s4, bk_s5;
	logic                v_s2, v_s3, v_s4, v_s5;
	logic [2:0][2*COORD_BITS-1:0] pl_s3, pr_s3;
	logic [HA_W-1:0]     hal_s4, har_s4;
	logic [PROD_W-1:0]   ml_s5, mr_s5;

	logic                found_q;
	logic [COST_W-1:0]   bcost_q;
	logic [1:0]          baxis_q;
	logic [BIN_W-1:0]    bbin_q;
	logic [CW-1:0]       bleft_q;
	res_t                res_q;
	logic                res_v_q;

	// node-level views
	sext_t [2:0]         cext, bext;
	logic [EXT_W-1:0]    ext;
	logic                store_ok;
	cent_t [2:0]         cin;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cext[a] = sext_t'(cmax_q[a]) - sext_t'(cmin_q[a]);
			bext[a] = sext_t'($signed(node_q.hi[a])) - sext_t'($signed(node_q.lo[a]));
			cin[a]  = cent_t'($signed(in_box.lo[a])) + cent_t'($signed(in_box.hi[a]));
		end
		ext      = cext[cmd.axis][EXT_W-1:0];
		store_ok = cnt_q < CW'(MAX_PRIMS);
	end

	// load: store the box and extend the node and centroid bounds
	always_ff @(posedge clk) begin
		if (cmd.ld && store_ok) mem[cnt_q[PW-1:0]] <= in_box;
		if (cmd.mem_rd) mem_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.fin) cnt_q <= '0;
			else if (cmd.ld && store_ok) cnt_q <= cnt_q + CW'(1);
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.bin_acc) idx_q <= idx_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			node_q <= '0;
			cmin_q <= '0;
			cmax_q <= '0;
		end else if (cmd.ld && store_ok) begin
			node_q <= (cnt_q == '0) ? in_box : box_union(node_q, in_box);
			for (int a = 0; a < 3; a++) begin
				if (cnt_q == '0 || cin[a] < cmin_q[a]) cmin_q[a] <= cin[a];
				if (cnt_q == '0 || cin[a] > cmax_q[a]) cmax_q[a] <= cin[a];
			end
		end
	end

	// bin thresholds: thr[j] = (j+1) * extent, built by accumulation
	logic [TW-1:0] thr_next;
	assign thr_next = (cmd.k == '0) ? TW'(ext) : thr_acc_q + TW'(ext);

	always_ff @(posedge clk) begin
		if (cmd.thr_wr) begin
			thr_q[cmd.k[BIN_W-1:0]] <= thr_next;
			thr_acc_q <= thr_next;
		end
	end

	// bin index of the stored primitive: count thresholds at or below 16 * offset
	cent_t            cm;
	logic [EXT_W:0]   off_w;
	logic [TW-1:0]    off16;
	logic [BIN_W-1:0] nb;

	always_comb begin
		cm    = cent_t'($signed(mem_q.lo[cmd.axis])) + cent_t'($signed(mem_q.hi[cmd.axis]));
		off_w = (EXT_W+1)'(sext_t'(cm) - sext_t'(cmin_q[cmd.axis]));
		off16 = {off_w[EXT_W-1:0], BIN_W'(0)};
		nb    = '0;
		for (int j = 0; j < NUM_BINS - 1; j++)
			nb = nb + BIN_W'(off16 >= thr_q[j]);
	end

	always_ff @(posedge clk) begin
		if (cmd.bin_calc) begin
			bin_s1 <= nb;
			box_s1 <= mem_q;
		end
	end

	// one read port on the bins: the accumulate slot or the sweep index
	logic [BIN_W-1:0] rd;
	logic [CW-1:0]    rcnt;
	box_t             rbox;
	assign rd   = cmd.bin_acc ? bin_s1 : cmd.k;
	assign rcnt = bcnt_q[rd];
	assign rbox = bbox_q[rd];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) bcnt_q[i] <= '0;
		end else if (cmd.thr_wr && cmd.k == '0) begin
			for (int i = 0; i < NUM_BINS; i++) bcnt_q[i] <= '0;
		end else if (cmd.bin_acc) begin
			bcnt_q[rd] <= rcnt + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bin_acc) bbox_q[rd] <= (rcnt == '0) ? box_s1 : box_union(rbox, box_s1);
	end

	// suffix and prefix sweeps
	logic [CW-1:0] suf_in, pre_in;
	box_t          suf_nx, pre_nx;
	always_comb begin
		suf_in = cmd.first ? '0 : suf_cnt_q;
		pre_in = cmd.first ? '0 : pre_cnt_q;
		suf_nx = suf_acc_q;
		pre_nx = pre_acc_q;
		if (rcnt != '0) begin
			suf_nx = (suf_in == '0) ? rbox : box_union(suf_acc_q, rbox);
			pre_nx = (pre_in == '0) ? rbox : box_union(pre_acc_q, rbox);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.suf_step) begin
			suf_acc_q      <= suf_nx;
			suf_cnt_q      <= suf_in + rcnt;
			suf_box_q[rd]  <= suf_nx;
			sc_q[rd]       <= suf_in + rcnt;
		end
		if (cmd.pre_step) begin
			pre_acc_q <= pre_nx;
			pre_cnt_q <= pre_in + rcnt;
			lk_s1     <= cmd.k;
		end
	end

	// cost pipeline, one split per launch
	logic [BIN_W-1:0] ki;
	box_t             rb;
	logic [CW-1:0]    rc;
	assign ki = lk_s1 + BIN_W'(1);
	assign rb = suf_box_q[ki];
	assign rc = sc_q[ki];

	logic [COST_W-1:0] cl_sat, cr_sat, cost_c;
	logic [COST_W:0]   csum;
	always_comb begin
		cl_sat = (ml_s5 > PROD_W'(COST_MAX)) ? COST_MAX : ml_s5[COST_W-1:0];
		cr_sat = (mr_s5 > PROD_W'(COST_MAX)) ? COST_MAX : mr_s5[COST_W-1:0];
		csum   = (COST_W+1)'(cl_sat) + (COST_W+1)'(cr_sat);
		cost_c = (csum > (COST_W+1)'(COST_MAX)) ? COST_MAX : csum[COST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_s1 <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
		end else begin
			lv_s1 <= cmd.pre_step;
			v_s2  <= lv_s1 && pre_cnt_q != '0 && rc != '0;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			dl_s2[a] <= side(pre_acc_q.lo[a], pre_acc_q.hi[a]);
			dr_s2[a] <= side(rb.lo[a], rb.hi[a]);
		end
		cl_s2 <= pre_cnt_q;
		cr_s2 <= rc;
		bk_s2 <= lk_s1;

		pl_s3[0] <= dl_s2[0] * dl_s2[1];
		pl_s3[1] <= dl_s2[1] * dl_s2[2];
		pl_s3[2] <= dl_s2[2] * dl_s2[0];
		pr_s3[0] <= dr_s2[0] * dr_s2[1];
		pr_s3[1] <= dr_s2[1] * dr_s2[2];
		pr_s3[2] <= dr_s2[2] * dr_s2[0];
		cl_s3 <= cl_s2;
		cr_s3 <= cr_s2;
		bk_s3 <= bk_s2;

		hal_s4 <= HA_W'(pl_s3[0]) + HA_W'(pl_s3[1]) + HA_W'(pl_s3[2]);
		har_s4 <= HA_W'(pr_s3[0]) + HA_W'(pr_s3[1]) + HA_W'(pr_s3[2]);
		cl_s4 <= cl_s3;
		cr_s4 <= cr_s3;
		bk_s4 <= bk_s3;

		ml_s5 <= PROD_W'(hal_s4) * PROD_W'(cl_s4);
		mr_s5 <= PROD_W'(har_s4) * PROD_W'(cr_s4);
		cl_s5 <= cl_s4;
		bk_s5 <= bk_s4;
	end

	// best split so far; strict compare keeps the first minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.best_clr) begin
			found_q <= 1'b0;
		end else if (v_s5 && (!found_q || cost_c < bcost_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.best_clr && v_s5 && (!found_q || cost_c < bcost_q)) begin
			bcost_q <= cost_c;
			baxis_q <= cmd.axis;
			bbin_q  <= bk_s5;
			bleft_q <= cl_s5;
		end
	end

	// result selection
	function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CW-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return (t > 32'((1 << CNT_W) - 1)) ? '1 : t[CNT_W-1:0];
	endfunction

	res_t res_nx;
	always_comb begin
		res_nx      = '0;
		res_nx.node = node_q;
		if (cnt_q < CW'(2)) begin
			res_nx.mode = MODE_LEAF;
		end else if (sts.all_zero) begin
			res_nx.mode = MODE_COINCIDENT;
			res_nx.axis = widest(bext[0], bext[1], bext[2]);
			res_nx.left = clamp_cnt(cnt_q >> 1);
		end else if (found_q) begin
			res_nx.mode = MODE_SAH;
			res_nx.axis = baxis_q;
			res_nx.bin  = bbin_q;
			res_nx.left = clamp_cnt(bleft_q);
			res_nx.cost = bcost_q;
		end else begin
			res_nx.mode = MODE_MEDIAN;
			res_nx.axis = widest(cext[0], cext[1], cext[2]);
			res_nx.left = clamp_cnt(cnt_q >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) res_q <= res_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (cmd.fin) res_v_q <= 1'b1;
		else if (res_ready) res_v_q <= 1'b0;
	end

	assign res       = res_q;
	assign res_valid = res_v_q;

	always_comb begin
		sts.n_lt2         = cnt_q < CW'(2);
		sts.all_zero      = cext[0] == '0 && cext[1] == '0 && cext[2] == '0;
		for (int a = 0; a < 3; a++) sts.ext_pos[a] = cext[a] > '0;
		sts.idx_last      = (CW'(idx_q) + CW'(1)) == cnt_q;
		sts.pipe_busy     = lv_s1 | v_s2 | v_s3 | v_s4 | v_s5;
		sts.res_slot_free = !res_v_q || res_ready;
	end

endmodule

// ===== sv/bsah_ctrl.sv =====
// Controller: sequences loading, per-axis binning, sweeps and result hand-off.
// Depends on bsah_pkg; commands bsah_datapath through cmd_t.
`timescale 1ns / 1ps

module bsah_ctrl import bsah_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		S_LOAD   = 12'b000000000001,
		S_CHK    = 12'b000000000010,
		S_AXCHK  = 12'b000000000100,
		S_TINIT  = 12'b000000001000,
		S_BRD    = 12'b000000010000,
		S_BWAIT  = 12'b000000100000,
		S_BACC   = 12'b000001000000,
		S_SUF    = 12'b000010000000,
		S_PRE    = 12'b000100000000,
		S_DRAIN  = 12'b001000000000,
		S_NEXTAX = 12'b010000000000,
		S_FIN    = 12'b100000000000
	} state_t;

	localparam logic [BIN_W-1:0] K_TOP  = BIN_W'(NUM_BINS - 1);
	localparam logic [BIN_W-1:0] K_LAST = BIN_W'(NUM_BINS - 2);

	state_t           state_q, state_d;
	logic [BIN_W-1:0] k_q, k_d;
	logic [1:0]       ax_q, ax_d;

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		ax_d     = ax_q;
		cmd      = '0;
		cmd.k    = k_q;
		cmd.axis = ax_q;
		in_ready = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				cmd.ld   = in_valid;
				if (in_valid && in_last) state_d = S_CHK;
			end
			S_CHK: begin
				cmd.best_clr = 1'b1;
				ax_d = AXIS_X;
				if (sts.n_lt2 || sts.all_zero) state_d = S_FIN;
				else state_d = S_AXCHK;
			end
			S_AXCHK: begin
				k_d = '0;
				if (sts.ext_pos[ax_q]) state_d = S_TINIT;
				else state_d = S_NEXTAX;
			end
			S_TINIT: begin
				cmd.thr_wr = 1'b1;
				if (k_q == K_LAST) begin
					cmd.idx_clr = 1'b1;
					state_d = S_BRD;
				end else begin
					k_d = k_q + BIN_W'(1);
				end
			end
			S_BRD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_BWAIT;
			end
			S_BWAIT: begin
				cmd.bin_calc = 1'b1;
				state_d = S_BACC;
			end
			S_BACC: begin
				cmd.bin_acc = 1'b1;
				if (sts.idx_last) begin
					k_d = K_TOP;
					state_d = S_SUF;
				end else begin
					state_d = S_BRD;
				end
			end
			S_SUF: begin
				cmd.suf_step = 1'b1;
				cmd.first = k_q == K_TOP;
				if (k_q == '0) state_d = S_PRE;
				else k_d = k_q - BIN_W'(1);
			end
			S_PRE: begin
				cmd.pre_step = 1'b1;
				cmd.first = k_q == '0;
				if (k_q == K_LAST) state_d = S_DRAIN;
				else k_d = k_q + BIN_W'(1);
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) state_d = S_NEXTAX;
			end
			S_NEXTAX: begin
				if (ax_q == AXIS_Z) begin
					state_d = S_FIN;
				end else begin
					ax_d = ax_q + 2'd1;
					state_d = S_AXCHK;
				end
			end
			S_FIN: begin
				if (sts.res_slot_free) begin
					cmd.fin = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			k_q     <= '0;
			ax_q    <= AXIS_X;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			ax_q    <= ax_d;
		end
	end

`ifndef SYNTH
	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !sts.res_slot_free) |=> state_q == S_FIN)
		else $error("result overwritten while previous result still pending");
	a_drain_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NEXTAX) |-> !sts.pipe_busy)
		else $error("axis advanced with cost pipeline still busy");
	a_sweep_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUF && k_q == '0) |=> (state_q == S_PRE && k_q == '0))
		else $error("prefix sweep did not follow suffix sweep");
`endif

endmodule
